### sv/triangle_face_normal_defines.svh
// Assertion macros for the triangle face normal top level.
// Needs clk and arst_n in scope where used.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication
`define TFN_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfn assertion failed");

// next-cycle implication
`define TFN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfn assertion failed");

`endif

### sv/tfn_pkg.sv
// Package for the triangle face normal pipeline: widths, step counts, sideband type.
// No dependencies.
`default_nettype none
package tfn_pkg;
	localparam int CoordW   = 24;
	localparam int EdgeW    = CoordW + 1;
	localparam int ProdW    = 2 * EdgeW;
	localparam int CrossW   = ProdW + 1;
	localparam int MagW     = 49;
	localparam int NormW    = 31;
	localparam int SumW     = 64;
	localparam int RootW    = SumW / 2;
	localparam int QuoW     = 31;
	localparam int OutW     = 32;
	localparam int SqSteps  = RootW;
	localparam int DivSteps = QuoW;

	typedef struct packed {
		logic [2:0][NormW-1:0] mag;
		logic [2:0]            neg;
		logic                  deg;
	} tfn_side_t;
endpackage
`default_nettype wire

### sv/tfn_front.sv
// Front of the pipeline: edges, cross product, magnitude, normalize, sum of squares.
// Depends on tfn_pkg.
`default_nettype none
module tfn_front import tfn_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [8:0][CoordW-1:0]       verts,
	output logic                         out_valid,
	output logic [SumW-1:0]              sum,
	output tfn_side_t                    side
);
	logic [7:0] vld_q;

	logic signed [2:0][EdgeW-1:0] e1_s1, e2_s1;
	logic signed [5:0][ProdW-1:0] p_s2;
	logic signed [2:0][CrossW-1:0] c_s3;
	logic [2:0][MagW-1:0] a_s4, a_s5;
	logic [MagW-1:0] or_s4;
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic deg_s4, deg_s5, deg_s6, deg_s7, deg_s8;
	logic [5:0] len_s5;
	logic [2:0][NormW-1:0] m_s6, m_s7, m_s8;
	logic [2:0][2*NormW-1:0] sq_s7;
	logic [SumW-1:0] sum_s8;

	logic [5:0] blen;
	always_comb begin
		blen = '0;
		for (int i = 0; i < MagW; i++) begin
			if (or_s4[i]) blen = 6'(i + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= $signed({verts[3+i][CoordW-1], verts[3+i]})
					- $signed({verts[i][CoordW-1], verts[i]});
				e2_s1[i] <= $signed({verts[6+i][CoordW-1], verts[6+i]})
					- $signed({verts[i][CoordW-1], verts[i]});
			end
			p_s2[0] <= $signed(e2_s1[1]) * $signed(e1_s1[2]);
			p_s2[1] <= $signed(e2_s1[2]) * $signed(e1_s1[1]);
			p_s2[2] <= $signed(e2_s1[2]) * $signed(e1_s1[0]);
			p_s2[3] <= $signed(e2_s1[0]) * $signed(e1_s1[2]);
			p_s2[4] <= $signed(e2_s1[0]) * $signed(e1_s1[1]);
			p_s2[5] <= $signed(e2_s1[1]) * $signed(e1_s1[0]);
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= $signed({p_s2[2*i][ProdW-1], p_s2[2*i]})
					- $signed({p_s2[2*i+1][ProdW-1], p_s2[2*i+1]});
			end
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= c_s3[i][CrossW-1];
				a_s4[i] <= c_s3[i][CrossW-1] ? MagW'(-c_s3[i]) : MagW'(c_s3[i]);
			end
			or_s4 <= MagW'(c_s3[0][CrossW-1] ? -c_s3[0] : c_s3[0])
				| MagW'(c_s3[1][CrossW-1] ? -c_s3[1] : c_s3[1])
				| MagW'(c_s3[2][CrossW-1] ? -c_s3[2] : c_s3[2]);
			deg_s4 <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);
			a_s5 <= a_s4;
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
			len_s5 <= blen;
			for (int i = 0; i < 3; i++) begin
				if (len_s5 < 6'(NormW)) begin
					m_s6[i] <= NormW'(a_s5[i] << (6'(NormW) - len_s5));
				end else begin
					m_s6[i] <= NormW'(a_s5[i] >> (len_s5 - 6'(NormW)));
				end
			end
			neg_s6 <= neg_s5;
			deg_s6 <= deg_s5;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= m_s6[i] * m_s6[i];
			end
			m_s7 <= m_s6;
			neg_s7 <= neg_s6;
			deg_s7 <= deg_s6;
			sum_s8 <= SumW'(sq_s7[0]) + SumW'(sq_s7[1]) + SumW'(sq_s7[2]);
			m_s8 <= m_s7;
			neg_s8 <= neg_s7;
			deg_s8 <= deg_s7;
		end
	end

	assign out_valid = vld_q[7];
	assign sum = sum_s8;
	assign side = '{mag: m_s8, neg: neg_s8, deg: deg_s8};
endmodule
`default_nettype wire

### sv/tfn_sqrt.sv
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on tfn_pkg.
`default_nettype none
module tfn_sqrt import tfn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SumW-1:0]  rad,
	input  tfn_side_t        in_side,
	output logic             out_valid,
	output logic [RootW-1:0] root,
	output tfn_side_t        out_side
);
	logic            vld_s  [SqSteps+1];
	logic [SumW-1:0] rad_s  [SqSteps+1];
	logic [RootW+1:0] rem_s [SqSteps+1];
	logic [RootW-1:0] root_s [SqSteps+1];
	tfn_side_t       side_s [SqSteps+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SqSteps; k++) begin : g_step
		logic [RootW+3:0] r_sh, trial, diff;
		logic ge;
		assign r_sh  = {rem_s[k], rad_s[k][SumW-1:SumW-2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign diff  = r_sh - trial;
		assign ge    = r_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][SumW-3:0], 2'b00};
				rem_s[k+1]  <= ge ? diff[RootW+1:0] : r_sh[RootW+1:0];
				root_s[k+1] <= {root_s[k][RootW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[SqSteps];
	assign root      = root_s[SqSteps];
	assign out_side  = side_s[SqSteps];
endmodule
`default_nettype wire

### sv/tfn_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, rounds half up.
// Depends on tfn_pkg.
`default_nettype none
module tfn_div import tfn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [RootW-1:0]       len,
	input  tfn_side_t              in_side,
	output logic                   out_valid,
	output logic [2:0][QuoW-1:0]   quo,
	output logic [2:0]             neg,
	output logic                   deg
);
	localparam int NumW = NormW + 30 + 1;

	logic                    vld_s  [DivSteps+1];
	logic [RootW-1:0]        len_s  [DivSteps+1];
	logic [2:0][RootW-1:0]   rem_s  [DivSteps+1];
	logic [2:0][QuoW-1:0]    low_s  [DivSteps+1];
	logic [2:0][QuoW-1:0]    quo_s  [DivSteps+1];
	logic [2:0]              neg_s  [DivSteps+1];
	logic                    deg_s  [DivSteps+1];

	logic [2:0][NumW-1:0] num;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num[l] = {1'b0, in_side.mag[l], 30'b0} + NumW'(len[RootW-1:1]);
			rem_s[0][l] = RootW'(num[l][NumW-1:QuoW]);
			low_s[0][l] = num[l][QuoW-1:0];
		end
	end

	assign vld_s[0] = in_valid;
	assign len_s[0] = len;
	assign quo_s[0] = '0;
	assign neg_s[0] = in_side.neg;
	assign deg_s[0] = in_side.deg;

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		logic [2:0][RootW:0] r_sh, diff;
		logic [2:0] ge;
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r_sh[l] = {rem_s[k][l], low_s[k][l][QuoW-1]};
				diff[l] = r_sh[l] - {1'b0, len_s[k]};
				ge[l]   = r_sh[l] >= {1'b0, len_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k+1][l] <= ge[l] ? diff[l][RootW-1:0] : r_sh[l][RootW-1:0];
					low_s[k+1][l] <= {low_s[k][l][QuoW-2:0], 1'b0};
					quo_s[k+1][l] <= {quo_s[k][l][QuoW-2:0], ge[l]};
				end
				len_s[k+1] <= len_s[k];
				neg_s[k+1] <= neg_s[k];
				deg_s[k+1] <= deg_s[k];
			end
		end
	end

	assign out_valid = vld_s[DivSteps];
	assign quo       = quo_s[DivSteps];
	assign neg       = neg_s[DivSteps];
	assign deg       = deg_s[DivSteps];
endmodule
`default_nettype wire

### sv/triangle_face_normal.sv
// Triangle unit face normal: cross product of edges, scaled to Q1.30.
// One triangle per cycle while the output is not stalled.
// Stages: 8 front stages, 32 square root stages, 31 divider stages, output register.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// arst_n clears all valid bits; no clearing pass.
`default_nettype none
`include "triangle_face_normal_defines.svh"
module triangle_face_normal import tfn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [215:0]  s_tdata,  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [95:0]   m_tdata,  // normal_x, normal_y, normal_z
	output logic          m_tuser   // degenerate
);
	logic en;
	logic fr_valid, sq_valid, dv_valid;
	logic [SumW-1:0] fr_sum;
	tfn_side_t fr_side, sq_side;
	logic [RootW-1:0] sq_root;
	logic [2:0][QuoW-1:0] dv_quo;
	logic [2:0] dv_neg;
	logic dv_deg;
	logic [2:0][OutW-1:0] norm_q;
	logic deg_q, vld_q;

	assign en = !vld_q || m_tready;
	assign s_tready = en;

	tfn_front u_front (
		.clk, .arst_n, .en,
		.in_valid  (s_tvalid),
		.verts     (s_tdata),
		.out_valid (fr_valid),
		.sum       (fr_sum),
		.side      (fr_side)
	);

	tfn_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid  (fr_valid),
		.rad       (fr_sum),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	tfn_div u_div (
		.clk, .arst_n, .en,
		.in_valid  (sq_valid),
		.len       (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.neg       (dv_neg),
		.deg       (dv_deg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (dv_deg) begin
					norm_q[l] <= '0;
				end else if (dv_neg[l]) begin
					norm_q[l] <= -{1'b0, dv_quo[l]};
				end else begin
					norm_q[l] <= {1'b0, dv_quo[l]};
				end
			end
			deg_q <= dv_deg;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = norm_q;
	assign m_tuser  = deg_q;

	logic [2:0] in_range, big;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			in_range[l] = ($signed(norm_q[l]) <= 32'sd1073741824)
				&& ($signed(norm_q[l]) >= -32'sd1073741824);
			big[l] = ($signed(norm_q[l]) >= 32'sd536870912)
				|| ($signed(norm_q[l]) <= -32'sd536870912);
		end
	end

	`TFN_ASSERT_IMPL(a_deg_zero, m_tvalid && m_tuser, m_tdata == '0)
	`TFN_ASSERT_IMPL(a_unit_range, m_tvalid, in_range == 3'b111)
	`TFN_ASSERT_IMPL(a_unit_major, m_tvalid && !m_tuser, big != 3'b000)
endmodule
`default_nettype wire

### test/tb.sv
// Testbench for triangle_face_normal: streams triangles and checks each unit normal.
// Depends on tfn_pkg and the triangle_face_normal RTL; predictor computed locally.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tfn_pkg::*;

	typedef struct packed {
		logic [OutW-1:0] nz;
		logic [OutW-1:0] ny;
		logic [OutW-1:0] nx;
		logic            deg;
	} normal_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [215:0]  s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [95:0]   m_tdata;
	logic          m_tuser;

	normal_t       normal_q[$];
	int            errors = 0;
	int            cycles = 0;
	bit            rx_hold = 1'b0;
	bit            no_idle = 1'b0;

	localparam int CycleLimit = 400000;
	localparam int Latency = 72;

	triangle_face_normal u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned num);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > num) b >>= 2;
		while (b != 0) begin
			if (num >= res + b) begin
				num -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic normal_t face_normal(logic [215:0] tri_w);
		longint p[9];
		longint e1[3], e2[3], c[3];
		longint unsigned a[3], mx, sum, len, q, v;
		int L;
		normal_t r;
		for (int i = 0; i < 9; i++) p[i] = longint'($signed(tri_w[i*CoordW +: CoordW]));
		for (int i = 0; i < 3; i++) begin
			e1[i] = p[3+i] - p[i];
			e2[i] = p[6+i] - p[i];
		end
		c[0] = e2[1]*e1[2] - e2[2]*e1[1];
		c[1] = e2[2]*e1[0] - e2[0]*e1[2];
		c[2] = e2[0]*e1[1] - e2[1]*e1[0];
		r = '0;
		if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
			r.deg = 1'b1;
			return r;
		end
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
			if (a[i] > mx) mx = a[i];
		end
		L = 0;
		while (mx != 0) begin
			L++;
			mx >>= 1;
		end
		for (int i = 0; i < 3; i++) a[i] = (L < NormW) ? a[i] << (NormW - L) : a[i] >> (L - NormW);
		sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		len = isqrt(sum);
		if (len == 0) len = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 30) + (len >> 1)) / len;
			v = c[i] < 0 ? (64'd0 - q) : q;
			case (i)
				0: r.nx = v[31:0];
				1: r.ny = v[31:0];
				default: r.nz = v[31:0];
			endcase
		end
		return r;
	endfunction

	function automatic logic [215:0] pack_tri(int c[9]);
		logic [215:0] w;
		for (int i = 0; i < 9; i++) w[i*CoordW +: CoordW] = c[i][CoordW-1:0];
		return w;
	endfunction

	task automatic send_triangle(logic [215:0] tri_w);
		s_tdata <= tri_w;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		normal_q = {normal_q, face_normal(tri_w)};
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic int rnd_coord();
		case ($urandom_range(5))
			0: return -8388608;
			1: return 8388607;
			2: return $urandom_range(64) - 32;
			default: return int'({$urandom} << 8) >>> 8;
		endcase
	endfunction

	// extremes, axis-aligned, degenerate cases, sign patterns
	task automatic test_directed();
		int c[9];
		c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_triangle(pack_tri(c));
		c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 0, 4096, 0, 0, 0, 4096};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 0, 0, 4096, 4096, 0, 0};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
		send_triangle(pack_tri(c));
		c = '{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
			-8388608, 8388607, -8388608};
		send_triangle(pack_tri(c));
		c = '{8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
			8388607, -8388608, 8388607};
		send_triangle(pack_tri(c));
		c = '{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
			-8388608, -8388608, 8388607};
		send_triangle(pack_tri(c));
		c = '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			8388607, -8388608, 8388607};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 1, 1, 0, 1, 1, 1};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 3, 0, 0, 0, 0, 0};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 1, 2, 3, 3, 2, 1};
		send_triangle(pack_tri(c));
		c = '{100, -200, 300, 100, -200, 300, 7, 8, 9};
		send_triangle(pack_tri(c));
		c = '{0, 0, 0, 8388607, 1, 0, 1, 8388607, 0};
		send_triangle(pack_tri(c));
		end_burst();
	endtask

	// random coordinates, including the edges of the coordinate range, and some raw random bits
	task automatic test_random(int n);
		int c[9];
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				send_triangle(216'({$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom}));
			end else begin
				for (int i = 0; i < 9; i++) c[i] = rnd_coord();
				if ($urandom_range(15) == 0) for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
				send_triangle(pack_tri(c));
			end
		end
		end_burst();
	endtask

	// unbroken stream at full rate
	task automatic test_back_to_back(int n);
		no_idle = 1'b1;
		test_random(n);
		no_idle = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure(int n);
		rx_hold = 1'b1;
		test_random(n);
		wait (!rx_hold);
	endtask

	always @(negedge clk) begin
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (no_idle) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 28);
		end
	end

	initial begin
		int hold_cycles;
		wait (rx_hold);
		hold_cycles = 0;
		while (hold_cycles < 300) begin
			@(posedge clk);
			hold_cycles++;
		end
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		normal_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[95:64], m_tdata[63:32], m_tdata[31:0], m_tuser};
			if (normal_q.size() == 0) begin
				$display("%0t: unexpected transaction %h deg %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = normal_q.pop_front();
				if (got.nx !== want.nx)
					$display("%0t: normal_x exp %h got %h", $time, want.nx, got.nx);
				if (got.ny !== want.ny)
					$display("%0t: normal_y exp %h got %h", $time, want.ny, got.ny);
				if (got.nz !== want.nz)
					$display("%0t: normal_z exp %h got %h", $time, want.nz, got.nz);
				if (got.deg !== want.deg)
					$display("%0t: degenerate exp %b got %b", $time, want.deg, got.deg);
				if (got !== want) errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(600);
		test_backpressure(200);
		test_back_to_back(300);
		test_random(630);
		wait (normal_q.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		if (errors == 0 && normal_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
